// ----- hw/rtl/pfa_pkg.sv -----
package pfa_pkg;

    // one command transaction
    typedef struct packed {
        logic        op;
        logic [15:0] process_id;
        logic [7:0]  process_size;
    } req_t;

    // one result transaction
    typedef struct packed {
        logic [2:0] status;
        logic [5:0] page_index;
        logic [5:0] frame;
        logic [6:0] free_frames;
        logic       last;
    } rsp_t;

    // command codes
    localparam logic OP_CREATE = 1'b0;
    localparam logic OP_LIST   = 1'b1;

    // status codes
    localparam logic [2:0] STAT_OK        = 3'd0;
    localparam logic [2:0] STAT_DUP_ID    = 3'd1;
    localparam logic [2:0] STAT_NOT_POW2  = 3'd2;
    localparam logic [2:0] STAT_TOO_LARGE = 3'd3;
    localparam logic [2:0] STAT_NO_MEM    = 3'd4;
    localparam logic [2:0] STAT_NOT_FOUND = 3'd5;

    // configuration register indexes
    localparam logic [1:0] CFG_FRAME_COUNT   = 2'd0;
    localparam logic [1:0] CFG_PAGE_LOG2     = 2'd1;
    localparam logic [1:0] CFG_MAX_PROC_LOG2 = 2'd2;

    localparam int CFG_W = 7;

    // process table control and status
    typedef struct packed {
        logic search;
        logic add;
    } ptab_req_t;

    typedef struct packed {
        logic done;
        logic found;
        logic full;
    } ptab_rsp_t;

endpackage

// ----- hw/rtl/pfa_ptab.sv -----
module pfa_ptab
    import pfa_pkg::*;
#(
    parameter int MAX_PROCESSES = 64,
    localparam int SLOT_W = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1,
    localparam int PC_W   = $clog2(MAX_PROCESSES + 1)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  ptab_req_t         ctl,
    input  logic [15:0]       key_id,
    input  logic [6:0]        add_pages,
    output ptab_rsp_t         stat,
    output logic [SLOT_W-1:0] slot,
    output logic [SLOT_W-1:0] next_slot,
    output logic [6:0]        pages
);

    logic [15:0] table_ids   [MAX_PROCESSES];
    logic [6:0]  table_pages [MAX_PROCESSES];

    logic [PC_W-1:0]   pc_reg, pc_next;
    logic [PC_W-1:0]   idx_reg, idx_next;
    logic              srch_reg, srch_next;
    logic              cmp_valid_reg, cmp_valid_next;
    logic [SLOT_W-1:0] cmp_slot_reg, cmp_slot_next;
    logic              done_reg, done_next;
    logic              found_reg, found_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [15:0]       ids_q;
    logic [6:0]        pages_q;
    logic              hit;
    logic              issue;

    // one table entry compared per cycle, read data registered and arriving the cycle after the address
    assign hit   = cmp_valid_reg && (ids_q == key_id);
    assign issue = srch_reg && !hit && (idx_reg < pc_reg);

    always_comb
    begin
        pc_next        = pc_reg;
        idx_next       = idx_reg;
        srch_next      = srch_reg;
        cmp_valid_next = 1'b0;
        cmp_slot_next  = cmp_slot_reg;
        done_next      = 1'b0;
        found_next     = found_reg;
        slot_next      = slot_reg;
        if (ctl.search)
        begin
            srch_next = 1'b1;
            idx_next  = '0;
        end
        else if (srch_reg)
        begin
            if (hit)
            begin
                srch_next  = 1'b0;
                done_next  = 1'b1;
                found_next = 1'b1;
                slot_next  = cmp_slot_reg;
            end
            else if (issue)
            begin
                idx_next       = idx_reg + 1'b1;
                cmp_valid_next = 1'b1;
                cmp_slot_next  = idx_reg[SLOT_W-1:0];
            end
            else if (!cmp_valid_reg)
            begin
                srch_next  = 1'b0;
                done_next  = 1'b1;
                found_next = 1'b0;
            end
        end
        if (ctl.add)
        begin
            pc_next = pc_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= '0;
            idx_reg       <= '0;
            srch_reg      <= 1'b0;
            cmp_valid_reg <= 1'b0;
            cmp_slot_reg  <= '0;
            done_reg      <= 1'b0;
            found_reg     <= 1'b0;
            slot_reg      <= '0;
        end
        else
        begin
            pc_reg        <= pc_next;
            idx_reg       <= idx_next;
            srch_reg      <= srch_next;
            cmp_valid_reg <= cmp_valid_next;
            cmp_slot_reg  <= cmp_slot_next;
            done_reg      <= done_next;
            found_reg     <= found_next;
            slot_reg      <= slot_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.add)
        begin
            table_ids[pc_reg[SLOT_W-1:0]]   <= key_id;
            table_pages[pc_reg[SLOT_W-1:0]] <= add_pages;
        end
        ids_q   <= table_ids[idx_reg[SLOT_W-1:0]];
        pages_q <= table_pages[slot_reg];
    end

    assign stat.done  = done_reg;
    assign stat.found = found_reg;
    assign stat.full  = (pc_reg == PC_W'(MAX_PROCESSES));
    assign slot       = slot_reg;
    assign next_slot  = pc_reg[SLOT_W-1:0];
    assign pages      = pages_q;

endmodule

// ----- hw/rtl/page_frame_allocator_unit.sv -----
// first-fit paging frame allocator, one command at a time under a small sequencer
// steps: table search, free frame count, decide, then allocation or a listing
// busy stays high until the last result; a new command is taken only while idle
// results are one-cycle strobes on rsp_valid, the receiver cannot stall
// reset: frame map cleared, process table empty, registers at 64 / 1 / 7
module page_frame_allocator_unit
    import pfa_pkg::*;
#(
    parameter int MAX_FRAMES    = 64,
    parameter int MAX_PROCESSES = 64
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  req_t             req,
    output logic             rsp_valid,
    output rsp_t             rsp,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    localparam int SLOT_W  = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
    localparam int FRAME_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int FIDX_W  = $clog2(MAX_FRAMES + 1);

    // sequencer states
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SEARCH = 3'd1;
    localparam logic [2:0] ST_COUNT  = 3'd2;
    localparam logic [2:0] ST_DECIDE = 3'd3;
    localparam logic [2:0] ST_ALLOC  = 3'd4;
    localparam logic [2:0] ST_LIST   = 3'd5;

    // configuration registers
    logic [6:0] frame_count_reg;
    logic [2:0] page_log2_reg;
    logic [2:0] max_proc_log2_reg;

    logic [2:0]        state_reg, state_next;
    req_t              req_reg, req_next;
    logic [MAX_FRAMES-1:0] used_reg, used_next;
    logic [FIDX_W-1:0] fi_reg, fi_next;
    logic [FIDX_W-1:0] free_reg, free_next;
    logic [7:0]        pages_reg, pages_next;
    logic [7:0]        got_reg, got_next;
    logic [FIDX_W-1:0] k_reg, k_next;
    logic              rsp_valid_reg, rsp_valid_next;
    rsp_t              rsp_reg, rsp_next;

    // listing pipeline: owner read is registered, arriving the cycle after the frame index
    logic               lv_reg, lv_next;
    logic               lused_reg, lused_next;
    logic [FRAME_W-1:0] lframe_reg, lframe_next;

    // frame owner memory
    logic [SLOT_W-1:0] frame_owner [MAX_FRAMES];
    logic [SLOT_W-1:0] owner_q;
    logic              owner_we;

    ptab_req_t         pt_req;
    ptab_rsp_t         pt_stat;
    logic [SLOT_W-1:0] pt_slot;
    logic [SLOT_W-1:0] pt_next_slot;
    logic [6:0]        pt_pages;

    logic [FIDX_W-1:0]  act;
    logic [FRAME_W-1:0] fidx;
    logic [8:0]         size_ext;
    logic [8:0]         max_size;
    logic [8:0]         round_sum;
    logic [8:0]         pages_calc;
    logic               not_pow2;
    logic               list_issue;
    logic               list_hit;
    logic               list_last;

    pfa_ptab #(
        .MAX_PROCESSES(MAX_PROCESSES)
    ) u_ptab (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (pt_req),
        .key_id    (req_reg.process_id),
        .add_pages (pages_reg[6:0]),
        .stat      (pt_stat),
        .slot      (pt_slot),
        .next_slot (pt_next_slot),
        .pages     (pt_pages)
    );

    // frames at or above the configured count are neither allocated nor counted
    assign act  = (frame_count_reg > 7'(MAX_FRAMES)) ? FIDX_W'(MAX_FRAMES)
                                                      : FIDX_W'(frame_count_reg);
    assign fidx = fi_reg[FRAME_W-1:0];

    // create checks
    assign size_ext   = {1'b0, req_reg.process_size};
    assign not_pow2   = (req_reg.process_size == 8'd0)
                        || ((req_reg.process_size & (req_reg.process_size - 8'd1)) != 8'd0);
    assign max_size   = 9'd1 << max_proc_log2_reg;
    assign round_sum  = size_ext + ((9'd1 << page_log2_reg) - 9'd1);
    assign pages_calc = round_sum >> page_log2_reg;

    // listing: stop issuing once the final page has been given
    assign list_hit   = lv_reg && lused_reg && (owner_q == pt_slot);
    assign list_last  = list_hit && ((8'(k_reg) + 8'd1) == {1'b0, pt_pages});
    assign list_issue = (state_reg == ST_LIST) && (fi_reg < FIDX_W'(MAX_FRAMES)) && !list_last;

    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        used_next      = used_reg;
        fi_next        = fi_reg;
        free_next      = free_reg;
        pages_next     = pages_reg;
        got_next       = got_reg;
        k_next         = k_reg;
        rsp_valid_next = 1'b0;
        rsp_next       = rsp_reg;
        lv_next        = list_issue;
        lused_next     = used_reg[fidx];
        lframe_next    = fidx;
        owner_we       = 1'b0;
        pt_req         = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    req_next      = req;
                    pt_req.search = 1'b1;
                    state_next    = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (pt_stat.done)
                begin
                    fi_next    = '0;
                    free_next  = '0;
                    state_next = ST_COUNT;
                end
            end
            ST_COUNT:
            begin
                if (fi_reg < act)
                begin
                    if (!used_reg[fidx])
                    begin
                        free_next = free_reg + 1'b1;
                    end
                    fi_next = fi_reg + 1'b1;
                end
                else
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                rsp_next.status      = STAT_OK;
                rsp_next.page_index  = '0;
                rsp_next.frame       = '0;
                rsp_next.free_frames = 7'(free_reg);
                rsp_next.last        = 1'b1;
                fi_next              = '0;
                got_next             = '0;
                k_next               = '0;
                pages_next           = pages_calc[7:0];
                if (req_reg.op == OP_CREATE)
                begin
                    priority if (pt_stat.found)
                    begin
                        rsp_next.status = STAT_DUP_ID;
                        rsp_valid_next  = 1'b1;
                        state_next      = ST_IDLE;
                    end
                    else if (not_pow2)
                    begin
                        rsp_next.status = STAT_NOT_POW2;
                        rsp_valid_next  = 1'b1;
                        state_next      = ST_IDLE;
                    end
                    else if (size_ext > max_size)
                    begin
                        rsp_next.status = STAT_TOO_LARGE;
                        rsp_valid_next  = 1'b1;
                        state_next      = ST_IDLE;
                    end
                    else if (pt_stat.full || (9'(free_reg) < pages_calc))
                    begin
                        rsp_next.status = STAT_NO_MEM;
                        rsp_valid_next  = 1'b1;
                        state_next      = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_ALLOC;
                    end
                end
                else
                begin
                    if (!pt_stat.found)
                    begin
                        rsp_next.status = STAT_NOT_FOUND;
                        rsp_valid_next  = 1'b1;
                        state_next      = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_LIST;
                    end
                end
            end
            ST_ALLOC:
            begin
                // first fit: claim free frames in ascending order
                if ((got_reg < pages_reg) && (fi_reg < act))
                begin
                    if (!used_reg[fidx])
                    begin
                        used_next[fidx] = 1'b1;
                        owner_we        = 1'b1;
                        got_next        = got_reg + 8'd1;
                    end
                    fi_next = fi_reg + 1'b1;
                end
                else
                begin
                    pt_req.add           = 1'b1;
                    rsp_next.status      = STAT_OK;
                    rsp_next.page_index  = '0;
                    rsp_next.frame       = '0;
                    rsp_next.free_frames = 7'(free_reg) - pages_reg[6:0];
                    rsp_next.last        = 1'b1;
                    rsp_valid_next       = 1'b1;
                    state_next           = ST_IDLE;
                end
            end
            ST_LIST:
            begin
                if (list_issue)
                begin
                    fi_next = fi_reg + 1'b1;
                end
                rsp_next.free_frames = 7'(free_reg);
                if (list_hit)
                begin
                    rsp_next.status     = STAT_OK;
                    rsp_next.page_index = 6'(k_reg);
                    rsp_next.frame      = 6'(lframe_reg);
                    rsp_next.last       = list_last;
                    rsp_valid_next      = 1'b1;
                    k_next              = k_reg + 1'b1;
                    if (list_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else if (!list_issue && !lv_reg)
                begin
                    // scan ran out without a page of this process
                    if (k_reg == '0)
                    begin
                        rsp_next.status     = STAT_NOT_FOUND;
                        rsp_next.page_index = '0;
                        rsp_next.frame      = '0;
                        rsp_next.last       = 1'b1;
                        rsp_valid_next      = 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            used_reg          <= '0;
            fi_reg            <= '0;
            free_reg          <= '0;
            pages_reg         <= '0;
            got_reg           <= '0;
            k_reg             <= '0;
            rsp_valid_reg     <= 1'b0;
            lv_reg            <= 1'b0;
            frame_count_reg   <= 7'd64;
            page_log2_reg     <= 3'd1;
            max_proc_log2_reg <= 3'd7;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            fi_reg        <= fi_next;
            free_reg      <= free_next;
            pages_reg     <= pages_next;
            got_reg       <= got_next;
            k_reg         <= k_next;
            rsp_valid_reg <= rsp_valid_next;
            lv_reg        <= lv_next;
            // register writes must only arrive while idle; the block itself does not enforce it
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_FRAME_COUNT:   frame_count_reg   <= cfg_data;
                    CFG_PAGE_LOG2:     page_log2_reg     <= cfg_data[2:0];
                    CFG_MAX_PROC_LOG2: max_proc_log2_reg <= cfg_data[2:0];
                    default:           ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        rsp_reg    <= rsp_next;
        lused_reg  <= lused_next;
        lframe_reg <= lframe_next;
    end

    // owner map: at most one write per cycle while allocating, one read per cycle while listing
    always_ff @(posedge clk)
    begin
        if (owner_we)
        begin
            frame_owner[fidx] <= pt_next_slot;
        end
        owner_q <= frame_owner[fidx];
    end

    assign busy      = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 100ps

module tb;
    import pfa_pkg::*;

    // block geometry, matches the defaults of the unit
    localparam int FRAMES   = 64;
    localparam int SLOTS    = 64;
    // cycles without any transaction before the run is called hung
    localparam int WATCHDOG = 4000;
    // settle time after the last expected result, a bit over one full command
    localparam int DRAIN    = 250;
    // random commands per phase, five phases
    localparam int PHASE_LEN = 50;

    // mirror of the allocator: frame map, process table and registers,
    // plus the queue of results still owed by the block
    class alloc_scoreboard;
        logic        used [FRAMES];
        logic [5:0]  owner [FRAMES];
        logic [15:0] pid [SLOTS];
        logic [6:0]  npages [SLOTS];
        int          nproc;
        logic [6:0]  frame_count;
        logic [2:0]  page_log2;
        logic [2:0]  max_log2;
        rsp_t        owed_q [$];
        int          errors;
        int          n_cmds;
        int          n_results;
        int          n_created;
        int          n_listed;

        function new();
            foreach (used[i])
            begin
                used[i]  = 1'b0;
                owner[i] = '0;
            end
            foreach (pid[i])
            begin
                pid[i]    = '0;
                npages[i] = '0;
            end
            nproc       = 0;
            frame_count = 7'd64;
            page_log2   = 3'd1;
            max_log2    = 3'd7;
            errors      = 0;
            n_cmds      = 0;
            n_results   = 0;
            n_created   = 0;
            n_listed    = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                CFG_FRAME_COUNT:   frame_count = val;
                CFG_PAGE_LOG2:     page_log2   = val[2:0];
                CFG_MAX_PROC_LOG2: max_log2    = val[2:0];
                default: ;
            endcase
        endfunction

        // frame counts above the physical size act as the physical size
        function int active_frames();
            return (frame_count > FRAMES) ? FRAMES : int'(frame_count);
        endfunction

        function int free_count();
            int n;
            n = 0;
            for (int i = 0; i < active_frames(); i++)
                if (!used[i])
                    n++;
            return n;
        endfunction

        function int find_slot(logic [15:0] id);
            for (int i = 0; i < nproc; i++)
                if (pid[i] == id)
                    return i;
            return -1;
        endfunction

        function void owe(logic [2:0] st, int page, int frm, int freec, bit fin);
            rsp_t e;
            e.status      = st;
            e.page_index  = 6'(page);
            e.frame       = 6'(frm);
            e.free_frames = 7'(freec);
            e.last        = fin;
            owed_q.push_back(e);
        endfunction

        // one accepted command: work out every result it owes
        function void note_command(req_t c);
            int slot;
            int freec;
            int pages;
            int k;
            int got;
            n_cmds++;
            slot  = find_slot(c.process_id);
            freec = free_count();
            if (c.op == OP_CREATE)
            begin
                if (slot >= 0)
                    owe(STAT_DUP_ID, 0, 0, freec, 1'b1);
                else if (c.process_size == 8'd0 ||
                         (c.process_size & (c.process_size - 8'd1)) != 8'd0)
                    owe(STAT_NOT_POW2, 0, 0, freec, 1'b1);
                else if (int'(c.process_size) > (1 << max_log2))
                    owe(STAT_TOO_LARGE, 0, 0, freec, 1'b1);
                else
                begin
                    pages = (int'(c.process_size) + (1 << page_log2) - 1) >> page_log2;
                    if (nproc >= SLOTS || freec < pages)
                        owe(STAT_NO_MEM, 0, 0, freec, 1'b1);
                    else
                    begin
                        // first fit, lowest free frame first
                        got = 0;
                        for (int i = 0; i < active_frames() && got < pages; i++)
                        begin
                            if (!used[i])
                            begin
                                used[i]  = 1'b1;
                                owner[i] = 6'(nproc);
                                got++;
                            end
                        end
                        pid[nproc]    = c.process_id;
                        npages[nproc] = 7'(pages);
                        nproc++;
                        n_created++;
                        owe(STAT_OK, 0, 0, free_count(), 1'b1);
                    end
                end
            end
            else if (slot < 0)
                owe(STAT_NOT_FOUND, 0, 0, freec, 1'b1);
            else
            begin
                // page order is ascending frame order, whole map is walked
                k = 0;
                n_listed++;
                for (int i = 0; i < FRAMES; i++)
                begin
                    if (k < npages[slot] && used[i] && owner[i] == 6'(slot))
                    begin
                        owe(STAT_OK, k, i, freec, (k + 1 == npages[slot]));
                        k++;
                    end
                end
                if (k == 0)
                    owe(STAT_NOT_FOUND, 0, 0, freec, 1'b1);
            end
        endfunction

        function void check_result(rsp_t r);
            rsp_t e;
            n_results++;
            if (owed_q.size() == 0)
            begin
                $error("result with nothing owed: status %0d page %0d frame %0d",
                       r.status, r.page_index, r.frame);
                errors++;
                return;
            end
            e = owed_q.pop_front();
            if (r.status !== e.status)
            begin
                $error("status: expected %0d, got %0d", e.status, r.status);
                errors++;
            end
            if (r.page_index !== e.page_index)
            begin
                $error("page_index: expected %0d, got %0d", e.page_index, r.page_index);
                errors++;
            end
            if (r.frame !== e.frame)
            begin
                $error("frame: expected %0d, got %0d", e.frame, r.frame);
                errors++;
            end
            if (r.free_frames !== e.free_frames)
            begin
                $error("free_frames: expected %0d, got %0d", e.free_frames, r.free_frames);
                errors++;
            end
            if (r.last !== e.last)
            begin
                $error("last: expected %0d, got %0d", e.last, r.last);
                errors++;
            end
        endfunction

        function int pending();
            return owed_q.size();
        endfunction
    endclass

    // everything the block sees is known from time zero
    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             start     = 1'b0;
    req_t             cmd       = '0;
    logic             cfg_we    = 1'b0;
    logic [1:0]       cfg_index = '0;
    logic [CFG_W-1:0] cfg_data  = '0;
    logic             busy;
    logic             rsp_valid;
    rsp_t             rsp;

    alloc_scoreboard sb = new();
    // sender gaps on or off, off for the last phase
    bit              idle_on = 1'b1;
    int              quiet   = 0;

    page_frame_allocator_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (cmd),
        .rsp_valid (rsp_valid),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 2 ns period
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // result side: every strobed transaction is checked at the edge that ends it;
    // the watchdog restarts on any transaction, command or result
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid)
                sb.check_result(rsp);
            if ((start && !busy) || rsp_valid)
                quiet <= 0;
            else if (quiet >= WATCHDOG)
            begin
                $display("tb: done, errors");
                $finish;
            end
            else
                quiet <= quiet + 1;
        end
    end

    function automatic req_t mk(logic op, logic [15:0] id, logic [7:0] size);
        req_t c;
        c.op           = op;
        c.process_id   = id;
        c.process_size = size;
        return c;
    endfunction

    // present one command and hold it until the block, idle again, has taken it;
    // called just after a rising edge, start may still be high from the last one
    task automatic issue(req_t c);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 17);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        cmd   <= c;
        do
            @(posedge clk);
        while (busy);
        sb.note_command(c);
    endtask

    // drop start and wait until every owed result is in and the block is free
    task automatic go_idle();
        start <= 1'b0;
        while (sb.pending() != 0 || busy)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        sb.set_reg(idx, val);
    endtask

    // all three registers, back to back, only while idle
    task automatic set_config(logic [CFG_W-1:0] fc, logic [2:0] pl, logic [2:0] ml);
        write_reg(CFG_FRAME_COUNT, fc);
        write_reg(CFG_PAGE_LOG2, 7'(pl));
        write_reg(CFG_MAX_PROC_LOG2, 7'(ml));
        cfg_we <= 1'b0;
    endtask

    // mostly well formed creates and listings of live processes,
    // the rest duplicates, oversize requests and raw noise
    function automatic req_t random_command();
        req_t c;
        int   pick;
        pick           = $urandom_range(0, 99);
        c.op           = OP_CREATE;
        c.process_id   = 16'($urandom);
        c.process_size = 8'($urandom);
        if (pick < 38)
            c.process_size = 8'(1 << $urandom_range(0, sb.max_log2));
        else if (pick < 75 && sb.nproc > 0)
        begin
            c.op         = OP_LIST;
            c.process_id = sb.pid[$urandom_range(0, sb.nproc - 1)];
        end
        else if (pick < 82 && sb.nproc > 0)
        begin
            c.process_id   = sb.pid[$urandom_range(0, sb.nproc - 1)];
            c.process_size = 8'(1 << $urandom_range(0, 7));
        end
        else if (pick < 88)
            c.process_size = 8'(1 << $urandom_range(0, 7));
        else
            c.op = 1'($urandom);
        return c;
    endfunction

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset registers: 64 frames, 2-byte pages, 128-byte limit
        issue(mk(OP_LIST,   16'h0000, 8'd0));    // unknown id
        issue(mk(OP_CREATE, 16'hFFFF, 8'd0));    // size zero is not a power of two
        issue(mk(OP_CREATE, 16'h0000, 8'd3));
        issue(mk(OP_CREATE, 16'h1234, 8'd255));
        issue(mk(OP_CREATE, 16'h0000, 8'd1));    // one page, frame 0
        issue(mk(OP_CREATE, 16'h0000, 8'd2));    // duplicate id, the size itself is valid
        issue(mk(OP_LIST,   16'h0000, 8'd0));
        issue(mk(OP_CREATE, 16'hFFFF, 8'd8));    // four pages
        issue(mk(OP_LIST,   16'hFFFF, 8'd0));
        issue(mk(OP_CREATE, 16'hAAAA, 8'd128));  // 64 pages, not enough left

        // no frames at all, tiny pages and limit
        go_idle();
        set_config(7'd0, 3'd0, 3'd0);
        issue(mk(OP_CREATE, 16'h5555, 8'd2));    // above the limit
        issue(mk(OP_CREATE, 16'h5555, 8'd1));    // no frames to allocate
        issue(mk(OP_LIST,   16'hFFFF, 8'd0));    // pages past the frame count still listed

        // frame count above the physical size clamps
        go_idle();
        set_config(7'd127, 3'd0, 3'd7);
        issue(mk(OP_CREATE, 16'h00FF, 8'd32));   // long page table
        issue(mk(OP_LIST,   16'h00FF, 8'd0));
        issue(mk(OP_CREATE, 16'h8000, 8'd128));

        // frame count lowered below frames already taken
        go_idle();
        set_config(7'd20, 3'd7, 3'd7);
        issue(mk(OP_CREATE, 16'h0007, 8'd64));
        issue(mk(OP_LIST,   16'h00FF, 8'd0));    // page count from create time
        issue(mk(OP_LIST,   16'h5555, 8'd0));

        // random phases, each under its own register setting
        for (int ph = 0; ph < 5; ph++)
        begin
            go_idle();
            case (ph)
                0: set_config(7'd64, 3'd7, 3'($urandom_range(0, 7)));
                1: set_config(7'($urandom_range(1, 64)), 3'($urandom_range(4, 7)), 3'd7);
                2: set_config(7'd1, 3'd0, 3'd7);
                3: set_config(7'd127, 3'd6, 3'($urandom_range(0, 7)));
                default:
                begin
                    set_config(7'd64, 3'($urandom_range(5, 7)), 3'd7);
                    idle_on = 1'b0;
                end
            endcase
            repeat (PHASE_LEN) issue(random_command());
        end

        go_idle();
        repeat (DRAIN) @(posedge clk);

        $display("tb: %0d commands, %0d results checked", sb.n_cmds, sb.n_results);
        $display("tb: %0d processes created, %0d page tables listed, %0d frames free",
                 sb.n_created, sb.n_listed, sb.free_count());
        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/pfa_pkg.sv
hw/rtl/pfa_ptab.sv
hw/rtl/page_frame_allocator_unit.sv
sim/tb.sv
